// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define MCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcf assertion failed");

// Next-cycle implication, masked during reset.
`define MCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcf assertion failed");

`endif

// ===== rtl/mcf_pkg.sv =====
// Types, frame constants and the CRC-16 byte update of the command framer.
// No dependencies; used by the top level, front end, back end and result queue.
`default_nettype none

package mcf_pkg;

    localparam logic [7:0]  HdrByte = 8'h3E;
    localparam logic [7:0]  LenByte = 8'h08;
    localparam logic [7:0]  FcRead  = 8'h92;
    localparam logic [7:0]  FcSet   = 8'hA4;
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;
    localparam logic [15:0] AngleMin = 16'd1000;
    localparam logic [15:0] AngleMax = 16'd35000;

    localparam logic [3:0] IdxHdr    = 4'd0;
    localparam logic [3:0] IdxId     = 4'd1;
    localparam logic [3:0] IdxLen    = 4'd2;
    localparam logic [3:0] IdxFunc   = 4'd3;
    localparam logic [3:0] IdxDir    = 4'd4;
    localparam logic [3:0] IdxSpdLo  = 4'd5;
    localparam logic [3:0] IdxSpdHi  = 4'd6;
    localparam logic [3:0] IdxGoalLo = 4'd7;
    localparam logic [3:0] IdxGoalHi = 4'd8;
    localparam logic [3:0] IdxCrcLo  = 4'd11;
    localparam logic [3:0] IdxCrcHi  = 4'd12;

    typedef struct packed {
        logic        reject;
        logic        is_set;
        logic [7:0]  motor_id;
        logic [7:0]  direction;
        logic [15:0] speed;
        logic [15:0] goal;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       rejected;
    } res_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            a = a[0] ? ((a >> 1) ^ CrcPoly) : (a >> 1);
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/motor_command_framer_crc16.sv =====
// Motor command framer: top level joining front end, back end and result queue.
// Depends on mcf_pkg, mcf_front, mcf_back and mcf_out_queue.
//
// Input channel: a command transfer happens on a rising edge with push high and
// full low. A read command yields a 13-byte frame; a set command with a goal
// angle inside 1000..35000 centidegrees yields a 13-byte frame, otherwise a
// single result with rejected and last set and out_byte zero.
// Result channel: the oldest result sits on out_byte/last/rejected while empty
// is low; a transfer happens on a rising edge with pop high and empty low.
// Bytes come in transmit order, last marks byte 12, the high CRC byte.
// Path: a command is registered in the command queue, its results in the result queue.
// Throughput: one byte per cycle from the back end while the result queue is not full,
// and a single result per rejected command; the frame walker and its CRC-16 byte update
// set that rate. The command queue holds two commands, the one being walked among them.
// Stalls: with pop low the result queue fills, the walker holds its place and
// the command queue fills until full rises; nothing is dropped.
// Reset: both queues empty, the walker returns to byte 0 and the CRC to 0xFFFF.
`default_nettype none

module motor_command_framer_crc16 (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         command,
    input  wire logic [7:0]   motor_id,
    input  wire logic [7:0]   direction,
    input  wire logic [15:0]  speed,
    input  wire logic [15:0]  goal_centideg,
    output logic              empty,
    input  wire logic         pop,
    output logic [7:0]        out_byte,
    output logic              last,
    output logic              rejected
);
    import mcf_pkg::*;

    logic head_valid;
    cmd_t head;
    logic head_take;
    logic oq_full;
    logic oq_push;
    res_t oq_data;
    res_t res;

    mcf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .motor_id      (motor_id),
        .direction     (direction),
        .speed         (speed),
        .goal_centideg (goal_centideg),
        .head_valid    (head_valid),
        .head          (head),
        .head_take     (head_take)
    );

    mcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_take  (head_take),
        .oq_full    (oq_full),
        .oq_push    (oq_push),
        .oq_data    (oq_data)
    );

    mcf_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_data (oq_data),
        .wr_full (oq_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res)
    );

    assign out_byte = res.out_byte;
    assign last     = res.last;
    assign rejected = res.rejected;

endmodule

`default_nettype wire

// ===== rtl/mcf_front.sv =====
// Front end: accepts commands, checks the goal angle, holds a two-entry command queue.
// Depends on mcf_pkg.
`default_nettype none

module mcf_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         command,
    input  wire logic [7:0]   motor_id,
    input  wire logic [7:0]   direction,
    input  wire logic [15:0]  speed,
    input  wire logic [15:0]  goal_centideg,
    output logic              head_valid,
    output mcf_pkg::cmd_t     head,
    input  wire logic         head_take
);
    import mcf_pkg::*;

    cmd_t       slot_reg [2];
    cmd_t       cls;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_take;

    always_comb
    begin
        cls.is_set    = command;
        cls.reject    = command && ((goal_centideg < AngleMin) || (goal_centideg > AngleMax));
        cls.motor_id  = motor_id;
        cls.direction = direction;
        cls.speed     = speed;
        cls.goal      = goal_centideg;
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_take    = head_take && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mcf_back.sv =====
// Back end: walks the head frame, runs the CRC-16; a byte a cycle unless oq_full.
// Depends on mcf_pkg.
`default_nettype none

module mcf_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  mcf_pkg::cmd_t     head,
    output logic              head_take,
    input  wire logic         oq_full,
    output logic              oq_push,
    output mcf_pkg::res_t     oq_data
);
    import mcf_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  frame_byte;
    logic        at_end;

    always_comb
    begin
        case (idx_reg)
            IdxHdr:    frame_byte = HdrByte;
            IdxId:     frame_byte = head.motor_id;
            IdxLen:    frame_byte = LenByte;
            IdxFunc:   frame_byte = head.is_set ? FcSet : FcRead;
            IdxDir:    frame_byte = head.is_set ? head.direction : 8'h00;
            IdxSpdLo:  frame_byte = head.is_set ? head.speed[7:0] : 8'h00;
            IdxSpdHi:  frame_byte = head.is_set ? head.speed[15:8] : 8'h00;
            IdxGoalLo: frame_byte = head.is_set ? head.goal[7:0] : 8'h00;
            IdxGoalHi: frame_byte = head.is_set ? head.goal[15:8] : 8'h00;
            IdxCrcLo:  frame_byte = crc_reg[7:0];
            IdxCrcHi:  frame_byte = crc_reg[15:8];
            default:   frame_byte = 8'h00;
        endcase
    end

    assign at_end    = (idx_reg == IdxCrcHi);
    assign oq_push   = head_valid && !oq_full;
    assign head_take = oq_push && (head.reject || at_end);

    always_comb
    begin
        oq_data.out_byte = head.reject ? 8'h00 : frame_byte;
        oq_data.last     = head.reject || at_end;
        oq_data.rejected = head.reject;
    end

    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (oq_push && !head.reject)
        begin
            if (at_end)
            begin
                idx_next = IdxHdr;
                crc_next = CrcInit;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg < IdxCrcLo)
                begin
                    crc_next = crc_feed(crc_reg, frame_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IdxHdr;
            crc_reg <= CrcInit;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mcf_out_queue.sv =====
// Two-entry result queue between the back end and the result port.
// Depends on mcf_pkg.
`default_nettype none

module mcf_out_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  mcf_pkg::res_t     wr_data,
    output logic              wr_full,
    output logic              empty,
    input  wire logic         pop,
    output mcf_pkg::res_t     rd_data
);
    import mcf_pkg::*;

    res_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !wr_full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mcf_checker.sv =====
// Port-level checker for the motor command framer, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mcf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] out_byte,
    input wire logic       last,
    input wire logic       rejected
);

    `MCF_ASSERT_NOW(a_reject_is_last, !empty && rejected, last)
    `MCF_ASSERT_NOW(a_reject_byte_zero, !empty && rejected, out_byte == 8'h00)
    `MCF_ASSERT_NEXT(a_no_reject_mid_frame, !empty && pop && !last, empty || !rejected)
    `MCF_ASSERT_NEXT(a_hold_on_stall, !empty && !pop, !empty && $stable(out_byte) && $stable(last))

endmodule

bind motor_command_framer_crc16 mcf_checker u_mcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .rejected (rejected)
);

`default_nettype wire
